// File: rtl/websocket_frame_deframer_macros.svh
// ============================================================================
// WebSocket frame deframer assertion macros
// Shared concurrent assertion forms used by the deframer RTL.
// ============================================================================
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// File: rtl/wsd_pkg.sv
// ============================================================================
// WebSocket deframer package
// Parser phases, event codes, opcode values and the result struct.
// ============================================================================
`timescale 1ns / 1ps

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_HALT    = 3'd5
    } t_phase;

    localparam logic [2:0] EV_DATA    = 3'd0;
    localparam logic [2:0] EV_PING    = 3'd1;
    localparam logic [2:0] EV_PONG    = 3'd2;
    localparam logic [2:0] EV_CLOSE   = 3'd3;
    localparam logic [2:0] EV_UNKNOWN = 3'd4;
    localparam logic [2:0] EV_BADLEN  = 3'd5;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Extended length byte counts, modulo eight as the 3-bit counter sees them.
    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] EXT64_BYTES = 3'd0;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [2:0] event_res;
        logic       has_byte;
        logic [7:0] payload_byte;
        logic       msg_last;
        logic       frame_end;
    } t_result;

    function automatic logic [2:0] opcode_event(input logic [3:0] opcode);
        logic [2:0] ev;
        case (opcode)
            OP_CONT, OP_TEXT, OP_BINARY: ev = EV_DATA;
            OP_PING:                     ev = EV_PING;
            OP_PONG:                     ev = EV_PONG;
            OP_CLOSE:                    ev = EV_CLOSE;
            default:                     ev = EV_UNKNOWN;
        endcase
        return ev;
    endfunction

endpackage

// File: rtl/wsd_parser.sv
// ============================================================================
// WebSocket deframer byte parser
// Holds the frame state and turns each accepted byte into at most one result.
// ============================================================================
`timescale 1ns / 1ps
`include "websocket_frame_deframer_macros.svh"

module wsd_parser
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_header_count, n_header_count;
    logic [63:0] r_payload_left, n_payload_left;
    logic [31:0] r_mask_key, n_mask_key;
    logic        r_mask_on, n_mask_on;
    logic [3:0]  r_frame_opcode, n_frame_opcode;
    logic        r_fin_flag, n_fin_flag;
    logic [1:0]  r_key_index, n_key_index;
    logic [6:0]  r_short_length, n_short_length;

    logic [2:0]  frame_ev;
    logic [7:0]  key_byte;
    logic        hdr_done;
    logic        last_byte;
    logic [2:0]  ext_need;
    t_result     res;

    assign frame_ev  = opcode_event(r_frame_opcode);
    assign last_byte = (r_payload_left == 64'd1);
    assign ext_need  = (r_short_length == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;

    always_comb begin
        case (r_key_index)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_header_count = r_header_count;
        n_payload_left = r_payload_left;
        n_mask_key     = r_mask_key;
        n_mask_on      = r_mask_on;
        n_frame_opcode = r_frame_opcode;
        n_fin_flag     = r_fin_flag;
        n_key_index    = r_key_index;
        n_short_length = r_short_length;
        hdr_done       = 1'b0;
        res            = '0;

        case (r_phase)
            PH_HDR0: begin
                n_fin_flag     = i_rx_byte[7];
                n_frame_opcode = i_rx_byte[3:0];
                n_phase        = PH_HDR1;
            end
            PH_HDR1: begin
                n_mask_on      = i_rx_byte[7];
                n_short_length = i_rx_byte[6:0];
                n_header_count = 3'd0;
                n_mask_key     = 32'd0;
                if (i_rx_byte[6:0] == LEN_EXT16 || i_rx_byte[6:0] == LEN_EXT64) begin
                    n_payload_left = 64'd0;
                    n_phase        = PH_EXTLEN;
                end else begin
                    n_payload_left = {57'd0, i_rx_byte[6:0]};
                    if (i_rx_byte[7]) begin
                        n_phase = PH_KEY;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_EXTLEN: begin
                n_payload_left = {r_payload_left[55:0], i_rx_byte};
                n_header_count = r_header_count + 3'd1;
                if (n_header_count == ext_need) begin
                    n_header_count = 3'd0;
                    if (ext_need == EXT64_BYTES && n_payload_left[63]) begin
                        n_phase         = PH_HALT;
                        res.valid       = 1'b1;
                        res.event_res   = EV_BADLEN;
                    end else if (r_mask_on) begin
                        n_phase = PH_KEY;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                n_mask_key     = {r_mask_key[23:0], i_rx_byte};
                n_header_count = r_header_count + 3'd1;
                if (n_header_count == KEY_BYTES) begin
                    n_header_count = 3'd0;
                    hdr_done       = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_key_index    = r_key_index + 2'd1;
                n_payload_left = r_payload_left - 64'd1;
                if (last_byte) begin
                    n_phase = PH_HDR0;
                end
                if (frame_ev == EV_DATA || frame_ev == EV_PING) begin
                    res.valid        = 1'b1;
                    res.event_res    = frame_ev;
                    res.has_byte     = 1'b1;
                    res.payload_byte = r_mask_on ? (i_rx_byte ^ key_byte) : i_rx_byte;
                    res.msg_last     = (frame_ev == EV_DATA) && last_byte && r_fin_flag;
                    res.frame_end    = last_byte;
                end else if (last_byte) begin
                    res.valid     = 1'b1;
                    res.event_res = frame_ev;
                    res.frame_end = 1'b1;
                end
            end
            PH_HALT: begin
                n_phase = PH_HALT;
            end
            default: begin
                n_phase = PH_HDR0;
            end
        endcase

        // Header finished: start the payload or close an empty frame here.
        if (hdr_done) begin
            n_key_index = 2'd0;
            if (n_payload_left != 64'd0) begin
                n_phase = PH_PAYLOAD;
            end else begin
                n_phase = PH_HDR0;
                if (frame_ev != EV_DATA || r_fin_flag) begin
                    res.valid     = 1'b1;
                    res.event_res = frame_ev;
                    res.msg_last  = (frame_ev == EV_DATA);
                    res.frame_end = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR0;
            r_header_count <= 3'd0;
            r_payload_left <= 64'd0;
            r_mask_key     <= 32'd0;
            r_mask_on      <= 1'b0;
            r_frame_opcode <= 4'd0;
            r_fin_flag     <= 1'b0;
            r_key_index    <= 2'd0;
            r_short_length <= 7'd0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_payload_left <= n_payload_left;
            r_mask_key     <= n_mask_key;
            r_mask_on      <= n_mask_on;
            r_frame_opcode <= n_frame_opcode;
            r_fin_flag     <= n_fin_flag;
            r_key_index    <= n_key_index;
            r_short_length <= n_short_length;
        end
    end

    assign o_res = res;

    // A bad length stops the parser for good.
    `WSD_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_phase == PH_HALT, r_phase == PH_HALT)
    // While in the payload phase there is always at least one byte left.
    `WSD_ASSERT_NOW(a_payload_nonzero, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_payload_left != 64'd0)
    // Payload bytes only come out of the payload phase.
    `WSD_ASSERT_NOW(a_byte_in_payload, i_clk, i_rst_n, res.valid && res.has_byte, r_phase == PH_PAYLOAD)
    // A message can only end together with its frame.
    `WSD_ASSERT_NOW(a_msg_end_frame, i_clk, i_rst_n, res.valid && res.msg_last, res.frame_end)

endmodule

// File: rtl/websocket_frame_deframer.sv
// ============================================================================
// WebSocket frame deframer
// Parses received frames one byte at a time, unmasks payload bytes and
// streams them out with data, ping and control events.
// ============================================================================
//
//   Channel  Direction  Handshake                 Payload
//   rx       in         i_rx_valid / o_rx_ready   i_rx_byte
//   res      out        o_res_valid / i_res_ready o_event_res, o_has_byte,
//                                                 o_payload_byte,
//                                                 o_msg_last, o_frame_end
//
// One received byte is taken per cycle while o_rx_ready is high. Its whole
// effect on the frame state is worked out combinationally while it is
// offered, and its result, if any, is captured in the output register at
// the accepting edge, so the result beat is offered from the next cycle on.
// The output register takes a new result while the previous one leaves in
// the same cycle, so back-pressure on the result side stalls the input only
// while a result is held and not being taken.
// Header bytes ahead of the last one and silent payload bytes of pong, close
// and unknown frames produce no result beat; they still pass at the full rate.
// Reset (synchronous, active low) puts the parser at the first header byte
// and empties the output register. After a bad 64-bit length the block
// keeps taking bytes but drops them until the next reset.
`timescale 1ns / 1ps

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_event_res,
    output logic       o_has_byte,
    output logic [7:0] o_payload_byte,
    output logic       o_msg_last,
    output logic       o_frame_end
);

    t_result    res;
    logic       rx_accept;

    logic       r_out_valid;
    logic [2:0] r_event_res;
    logic       r_has_byte;
    logic [7:0] r_payload_byte;
    logic       r_msg_last;
    logic       r_frame_end;

    // Room for a new beat when the output register is empty or draining now.
    assign o_rx_ready = !r_out_valid || i_res_ready;
    assign rx_accept  = i_rx_valid && o_rx_ready;

    wsd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_accept),
        .i_rx_byte (i_rx_byte),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rx_accept) begin
            r_out_valid <= res.valid;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload is loaded only when a new result beat is produced.
    always_ff @(posedge i_clk) begin
        if (rx_accept && res.valid) begin
            r_event_res    <= res.event_res;
            r_has_byte     <= res.has_byte;
            r_payload_byte <= res.payload_byte;
            r_msg_last     <= res.msg_last;
            r_frame_end    <= res.frame_end;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_event_res    = r_event_res;
    assign o_has_byte     = r_has_byte;
    assign o_payload_byte = r_payload_byte;
    assign o_msg_last     = r_msg_last;
    assign o_frame_end    = r_frame_end;

endmodule

// File: verif/websocket_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Streams received frames into the deframer one byte per beat and predicts
// every result beat with a frame parser of its own. A short directed set of
// frames comes first, then random frames under three idling patterns. A
// 64-bit length with its top bit set closes the run, with trailing bytes
// that must be dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
    import wsd_pkg::*;

    // Form of the length field in the second header byte.
    localparam int LEN_FORM_SHORT = 0;
    localparam int LEN_FORM_EXT16 = 1;
    localparam int LEN_FORM_EXT64 = 2;

    // An opcode that RFC 6455 leaves reserved for control frames.
    localparam logic [3:0] OP_RSVD_CTRL = 4'hF;

    localparam int BYTES_PER_PHASE = 590;
    localparam int TAIL_CYCLES     = 10;

    typedef struct packed {
        logic [2:0] ev;
        logic       has_byte;
        logic [7:0] data;
        logic       msg_end;
        logic       frame_end;
    } t_ws_beat;

    logic       i_clk;
    logic       rst_n     = 1'b0;
    logic       rx_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       res_ready = 1'b0;
    logic       rx_ready;
    logic       res_valid;
    logic [2:0] res_event;
    logic       res_has_byte;
    logic [7:0] res_payload;
    logic       res_msg_end;
    logic       res_frame_end;

    logic [7:0] rx_stream[$];
    t_ws_beat   pending_beats[$];
    int         src_idle_pct  = 38;
    int         sink_idle_pct = 67;
    int         fail_count    = 0;

    // Parser state of the prediction, at its reset values.
    t_phase      rx_phase  = PH_HDR0;
    logic [2:0]  hdr_cnt   = 3'd0;
    logic [63:0] bytes_left = 64'd0;
    logic [31:0] mask_word = 32'd0;
    logic        masked    = 1'b0;
    logic [3:0]  opcode    = 4'd0;
    logic        fin       = 1'b0;
    logic [1:0]  key_pos   = 2'd0;
    logic [6:0]  len_code  = 7'd0;

    websocket_frame_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_event_res    (res_event),
        .o_has_byte     (res_has_byte),
        .o_payload_byte (res_payload),
        .o_msg_last     (res_msg_end),
        .o_frame_end    (res_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [2:0] frame_event(input logic [3:0] op);
        case (op)
            OP_CONT, OP_TEXT, OP_BINARY: return EV_DATA;
            OP_PING:                     return EV_PING;
            OP_PONG:                     return EV_PONG;
            OP_CLOSE:                    return EV_CLOSE;
            default:                     return EV_UNKNOWN;
        endcase
    endfunction

    function automatic void note_beat(input logic [2:0] ev, input logic hb,
                                      input logic [7:0] d, input logic me,
                                      input logic fe);
        t_ws_beat beat;
        beat.ev        = ev;
        beat.has_byte  = hb;
        beat.data      = d;
        beat.msg_end   = me;
        beat.frame_end = fe;
        pending_beats.push_back(beat);
    endfunction

    // The header is complete: either start the payload or close an empty
    // frame right away. An empty data frame without fin says nothing.
    task automatic close_header();
        logic [2:0] ev;
        ev      = frame_event(opcode);
        key_pos = 2'd0;
        if (bytes_left != 64'd0) begin
            rx_phase = PH_PAYLOAD;
        end else begin
            rx_phase = PH_HDR0;
            if (ev == EV_DATA) begin
                if (fin)
                    note_beat(EV_DATA, 1'b0, 8'h00, 1'b1, 1'b1);
            end else begin
                note_beat(ev, 1'b0, 8'h00, 1'b0, 1'b1);
            end
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [2:0] ev;
        logic [2:0] need;
        logic [7:0] d;
        logic       last;
        case (rx_phase)
            PH_HDR0: begin
                // The three reserved bits are ignored.
                fin      = b[7];
                opcode   = b[3:0];
                rx_phase = PH_HDR1;
            end
            PH_HDR1: begin
                masked     = b[7];
                len_code   = b[6:0];
                hdr_cnt    = 3'd0;
                mask_word  = 32'd0;
                bytes_left = 64'd0;
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                    rx_phase = PH_EXTLEN;
                end else begin
                    bytes_left = {57'd0, b[6:0]};
                    if (masked)
                        rx_phase = PH_KEY;
                    else
                        close_header();
                end
            end
            PH_EXTLEN: begin
                need       = (len_code == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                bytes_left = {bytes_left[55:0], b};
                hdr_cnt    = hdr_cnt + 3'd1;
                if (hdr_cnt == need) begin
                    hdr_cnt = 3'd0;
                    if (len_code == LEN_EXT64 && bytes_left[63]) begin
                        rx_phase = PH_HALT;
                        note_beat(EV_BADLEN, 1'b0, 8'h00, 1'b0, 1'b0);
                    end else if (masked) begin
                        rx_phase = PH_KEY;
                    end else begin
                        close_header();
                    end
                end
            end
            PH_KEY: begin
                mask_word = {mask_word[23:0], b};
                hdr_cnt   = hdr_cnt + 3'd1;
                if (hdr_cnt == KEY_BYTES) begin
                    hdr_cnt = 3'd0;
                    close_header();
                end
            end
            PH_PAYLOAD: begin
                ev = frame_event(opcode);
                d  = b;
                // Key bytes are applied most significant first.
                if (masked)
                    d = b ^ mask_word[(3 - key_pos) * 8 +: 8];
                key_pos    = key_pos + 2'd1;
                bytes_left = bytes_left - 64'd1;
                last       = (bytes_left == 64'd0);
                if (last)
                    rx_phase = PH_HDR0;
                if (ev == EV_DATA)
                    note_beat(EV_DATA, 1'b1, d, last & fin, last);
                else if (ev == EV_PING)
                    note_beat(EV_PING, 1'b1, d, 1'b0, last);
                else if (last)
                    note_beat(ev, 1'b0, 8'h00, 1'b0, 1'b1);
            end
            default: begin
                // Halted: the byte is dropped.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_frame(input logic fin_bit, input logic [2:0] rsv,
                               input logic [3:0] op, input logic mask_bit,
                               input int form, input logic [63:0] len);
        logic [6:0] code;
        int         i;
        rx_stream.push_back({fin_bit, rsv, op});
        if (form == LEN_FORM_EXT16)
            code = LEN_EXT16;
        else if (form == LEN_FORM_EXT64)
            code = LEN_EXT64;
        else
            code = len[6:0];
        rx_stream.push_back({mask_bit, code});
        if (form == LEN_FORM_EXT16) begin
            rx_stream.push_back(len[15:8]);
            rx_stream.push_back(len[7:0]);
        end else if (form == LEN_FORM_EXT64) begin
            for (i = 7; i >= 0; i--)
                rx_stream.push_back(len[i * 8 +: 8]);
        end
        // A length with the top bit set halts the parser, so nothing follows.
        if (form == LEN_FORM_EXT64 && len[63])
            return;
        if (mask_bit)
            for (i = 0; i < 4; i++)
                rx_stream.push_back(8'($urandom_range(255)));
        for (i = 0; i < int'(len); i++)
            rx_stream.push_back(8'($urandom_range(255)));
    endtask

    task automatic queue_random_frame();
        int          r;
        int          form;
        logic [3:0]  op;
        logic [63:0] len;
        r = $urandom_range(15);
        if (r < 3)
            op = OP_CONT;
        else if (r < 6)
            op = OP_TEXT;
        else if (r < 8)
            op = OP_BINARY;
        else if (r < 10)
            op = OP_PING;
        else if (r < 11)
            op = OP_PONG;
        else if (r < 12)
            op = OP_CLOSE;
        else if (r < 14)
            op = 4'($urandom_range(3, 7));
        else
            op = 4'($urandom_range(11, 15));
        // Mostly short payloads; the extended forms carry small lengths so
        // that the run stays short.
        r    = $urandom_range(99);
        form = LEN_FORM_SHORT;
        if (r < 60) begin
            len = 64'($urandom_range(8));
        end else if (r < 85) begin
            len = 64'($urandom_range(9, 40));
        end else if (r < 93) begin
            len = 64'($urandom_range(41, 125));
        end else if (r < 97) begin
            form = LEN_FORM_EXT16;
            len  = 64'($urandom_range(300));
        end else begin
            form = LEN_FORM_EXT64;
            len  = 64'($urandom_range(60));
        end
        queue_frame(1'($urandom_range(1)), 3'($urandom_range(7)), op,
                    1'($urandom_range(1)), form, len);
    endtask

    // Holds the run back until every byte is in and every result is out.
    task automatic drain();
        while (rx_stream.size() != 0 || rx_valid || pending_beats.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers one byte per beat from rx_stream and predicts on accept.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end else begin
            if (rx_valid && rx_ready)
                parse_rx_byte(rx_byte);
            if (!rx_valid || rx_ready) begin
                if (rx_stream.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    rx_valid <= 1'b1;
                    rx_byte  <= rx_stream.pop_front();
                end else begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every result beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ws_beat want;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                if (pending_beats.size() == 0) begin
                    $error("result beat with nothing expected: event_res %0d", res_event);
                    fail_count++;
                end else begin
                    want = pending_beats.pop_front();
                    if (res_event !== want.ev) begin
                        $error("event_res expected %0d got %0d", want.ev, res_event);
                        fail_count++;
                    end
                    if (res_has_byte !== want.has_byte) begin
                        $error("has_byte expected %0d got %0d", want.has_byte,
                               res_has_byte);
                        fail_count++;
                    end
                    if (res_payload !== want.data) begin
                        $error("payload_byte expected %02h got %02h", want.data,
                               res_payload);
                        fail_count++;
                    end
                    if (res_msg_end !== want.msg_end) begin
                        $error("msg_last expected %0d got %0d", want.msg_end,
                               res_msg_end);
                        fail_count++;
                    end
                    if (res_frame_end !== want.frame_end) begin
                        $error("frame_end expected %0d got %0d", want.frame_end,
                               res_frame_end);
                        fail_count++;
                    end
                end
            end
            res_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        logic [63:0] bad_len;
        int          i;
        while (!rst_n)
            @(negedge i_clk);

        // Directed frames: empty data with and without fin, an empty masked
        // ping, a one-byte pong, a masked close, an empty unknown opcode and
        // a masked binary frame with a 16-bit length.
        queue_frame(1'b1, 3'b000, OP_TEXT,      1'b0, LEN_FORM_SHORT, 64'd0);
        queue_frame(1'b0, 3'b111, OP_CONT,      1'b0, LEN_FORM_SHORT, 64'd0);
        queue_frame(1'b1, 3'b000, OP_PING,      1'b1, LEN_FORM_SHORT, 64'd0);
        queue_frame(1'b1, 3'b000, OP_PONG,      1'b0, LEN_FORM_SHORT, 64'd1);
        queue_frame(1'b1, 3'b101, OP_CLOSE,     1'b1, LEN_FORM_SHORT, 64'd2);
        queue_frame(1'b1, 3'b000, OP_RSVD_CTRL, 1'b0, LEN_FORM_SHORT, 64'd0);
        queue_frame(1'b0, 3'b000, OP_BINARY,    1'b1, LEN_FORM_EXT16, 64'd1);
        drain();

        // Sender idles now and then, receiver often... then the reverse.
        while (rx_stream.size() < BYTES_PER_PHASE)
            queue_random_frame();
        drain();

        src_idle_pct  = 67;
        sink_idle_pct = 38;
        while (rx_stream.size() < BYTES_PER_PHASE)
            queue_random_frame();
        drain();

        // Full rate on both sides.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (rx_stream.size() < BYTES_PER_PHASE)
            queue_random_frame();

        // A 64-bit length with the top bit set halts the parser; the bytes
        // after it must all be dropped without a result.
        bad_len = {1'b1, 31'($urandom), 32'($urandom)};
        queue_frame(1'b1, 3'b000, OP_BINARY, 1'($urandom_range(1)), LEN_FORM_EXT64,
                    bad_len);
        for (i = 0; i < 24; i++)
            rx_stream.push_back(8'($urandom_range(255)));
        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer.sv
verif/websocket_frame_deframer_tb.sv
